// ===== src/gtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants for the go-to-point controller
// Beat formats, command and status codes, fixed-point widths and the
// arctangent table used by the shift-add vectoring unit.
// ----------------------------------------------------------------------------
package gtp_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_GAIN = 1'b1;

    localparam logic [15:0] LINEAR_GAIN_RESET  = 16'd410;
    localparam logic [15:0] ANGULAR_GAIN_RESET = 16'd2048;

    // Command codes
    localparam logic [1:0] CMD_POSE   = 2'd0;
    localparam logic [1:0] CMD_TARGET = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_POSE   = 2'd1;
    localparam logic [1:0] STATUS_NO_TARGET = 2'd2;

    // Datapath widths
    localparam int VEC_W   = 43;  // vectoring x/y after normalization and growth
    localparam int Z_W     = 33;  // binary angle accumulator, pi = 2^31
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 66;
    localparam int Q_W     = 35;  // quaternion product sums
    localparam int DIST_W  = 34;
    localparam int RAD_W   = 22;
    localparam int ERR_W   = 23;
    localparam int SHIFT_W = 6;

    localparam int CORDIC_STEPS = 28;

    // 1/K in Q30 and pi in Q30, each split into 16-bit halves
    localparam logic [15:0] KINV_HI = 16'h26DD;
    localparam logic [15:0] KINV_LO = 16'h3B6A;
    localparam logic [15:0] PI_HI   = 16'hC90F;
    localparam logic [15:0] PI_LO   = 16'hDAA2;

    typedef struct packed {
        logic        [1:0]  command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
    } in_item_t;

    typedef struct packed {
        logic        [30:0] linear_speed;
        logic signed [31:0] angular_rate;
        logic        [1:0]  status;
    } out_item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_VSTART,
        ST_NORM,
        ST_PRE,
        ST_ITER,
        ST_MAG0,
        ST_MAG1,
        ST_MAG2,
        ST_MAG3,
        ST_QMUL,
        ST_QCHK,
        ST_RAD0,
        ST_RAD1,
        ST_RAD2,
        ST_RAD3,
        ST_RAD4,
        ST_RAD5,
        ST_GAIN0,
        ST_GAIN1,
        ST_DONE
    } gtp_state_t;

    // atan(2^-i) in binary angle units, pi = 2^31
    function automatic logic [29:0] atan_ba(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:    val = 30'd536870912;
            5'd1:    val = 30'd316933406;
            5'd2:    val = 30'd167458907;
            5'd3:    val = 30'd85004756;
            5'd4:    val = 30'd42667331;
            5'd5:    val = 30'd21354465;
            5'd6:    val = 30'd10679838;
            5'd7:    val = 30'd5340245;
            5'd8:    val = 30'd2670163;
            5'd9:    val = 30'd1335087;
            5'd10:   val = 30'd667544;
            5'd11:   val = 30'd333772;
            5'd12:   val = 30'd166886;
            5'd13:   val = 30'd83443;
            5'd14:   val = 30'd41722;
            5'd15:   val = 30'd20861;
            5'd16:   val = 30'd10430;
            5'd17:   val = 30'd5215;
            5'd18:   val = 30'd2608;
            5'd19:   val = 30'd1304;
            5'd20:   val = 30'd652;
            5'd21:   val = 30'd326;
            5'd22:   val = 30'd163;
            5'd23:   val = 30'd81;
            5'd24:   val = 30'd41;
            5'd25:   val = 30'd20;
            5'd26:   val = 30'd10;
            5'd27:   val = 30'd5;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== src/go_to_point_p_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_point_p_controller: proportional go-to-goal drive controller
// Input beats carry a pose update, a target update or a tick. Each tick
// produces one output beat with linear speed, angular rate and status.
//
// Usage:
//   in_valid/in_ready/in_data take one beat; out_valid/out_ready/out_data
//   deliver one result beat per tick. cfg_wr_en/cfg_index/cfg_data write
//   the Q4.12 gains (index 0 linear, index 1 angular). Pose and target
//   updates are stored as their beat is accepted. A tick with pose or
//   target unknown goes straight to its final state and presents its zero
//   command from there. A full tick runs two passes of the shared 28-step
//   shift-add vectoring unit (bearing and distance, then yaw), each after
//   a normalization, plus the products on the 35x17 multiplier.
//   A goal on the robot or a degenerate quaternion skips a pass.
//   in_ready is high only while the sequencer is idle.
//   Reset clears the pose and target known flags and loads the default
//   gains. A result waits in the output register while out_ready is low;
//   the next beat is still accepted, and a later tick holds in its final
//   state until the output register is free.
// ----------------------------------------------------------------------------
module go_to_point_p_controller
    import gtp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    // Control state
    gtp_state_t          state_reg, state_next;
    logic                pose_known_reg, pose_known_next;
    logic                target_known_reg, target_known_next;
    logic [15:0]         lin_gain_reg, lin_gain_next;
    logic [15:0]         ang_gain_reg, ang_gain_next;
    logic                out_valid_reg, out_valid_next;
    logic                yaw_mode_reg, yaw_mode_next;
    logic [4:0]          iter_reg, iter_next;
    logic [3:0]          qstep_reg, qstep_next;

    // Stored pose and target
    logic signed [31:0]  rob_x_reg, rob_x_next;
    logic signed [31:0]  rob_y_reg, rob_y_next;
    logic signed [15:0]  qx_reg, qx_next;
    logic signed [15:0]  qy_reg, qy_next;
    logic signed [15:0]  qz_reg, qz_next;
    logic signed [15:0]  qw_reg, qw_next;
    logic signed [31:0]  tgt_x_reg, tgt_x_next;
    logic signed [31:0]  tgt_y_reg, tgt_y_next;

    // Working datapath
    logic signed [VEC_W-1:0]  vx_reg, vx_next;
    logic signed [VEC_W-1:0]  vy_reg, vy_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic [SHIFT_W-1:0]       shift_reg, shift_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [Q_W-1:0]    n_reg, n_next;
    logic signed [Q_W-1:0]    yz_reg, yz_next;
    logic signed [Q_W-1:0]    num_reg, num_next;
    logic signed [Q_W-1:0]    g_reg, g_next;
    logic [DIST_W-1:0]        dist_reg, dist_next;
    logic signed [Z_W-1:0]    bearing_reg, bearing_next;
    logic signed [RAD_W-1:0]  brad_reg, brad_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [30:0]              res_lin_reg, res_lin_next;
    logic signed [31:0]       res_ang_reg, res_ang_next;
    logic [1:0]               res_status_reg, res_status_next;
    out_item_t                out_reg, out_next;

    // Shared multiplier operands
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        logic signed [VEC_W-1:0]  ax;
        logic signed [VEC_W-1:0]  ay;
        logic signed [VEC_W-1:0]  xs;
        logic signed [VEC_W-1:0]  ys;
        logic signed [15:0]       qa;
        logic signed [15:0]       qb;
        logic signed [Q_W-1:0]    qprod;
        logic [2:0]               qprev;
        logic signed [Q_W:0]      g2;
        logic signed [Q_W:0]      g2_abs;
        logic signed [Q_W:0]      den;
        logic [ACC_W-1:0]         acc_u;
        logic signed [PROD_W-1:0] rounded;
        logic signed [PROD_W-13:0] scaled;

        state_next        = state_reg;
        pose_known_next   = pose_known_reg;
        target_known_next = target_known_reg;
        lin_gain_next     = lin_gain_reg;
        ang_gain_next     = ang_gain_reg;
        yaw_mode_next     = yaw_mode_reg;
        iter_next         = iter_reg;
        qstep_next        = qstep_reg;
        rob_x_next        = rob_x_reg;
        rob_y_next        = rob_y_reg;
        qx_next           = qx_reg;
        qy_next           = qy_reg;
        qz_next           = qz_reg;
        qw_next           = qw_reg;
        tgt_x_next        = tgt_x_reg;
        tgt_y_next        = tgt_y_reg;
        vx_next           = vx_reg;
        vy_next           = vy_reg;
        z_next            = z_reg;
        shift_next        = shift_reg;
        acc_next          = acc_reg;
        n_next            = n_reg;
        yz_next           = yz_reg;
        num_next          = num_reg;
        g_next            = g_reg;
        dist_next         = dist_reg;
        bearing_next      = bearing_reg;
        brad_next         = brad_reg;
        err_next          = err_reg;
        res_lin_next      = res_lin_reg;
        res_ang_next      = res_ang_reg;
        res_status_next   = res_status_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        mul_a             = '0;
        mul_b             = '0;

        ax      = vx_reg[VEC_W-1] ? -vx_reg : vx_reg;
        ay      = vy_reg[VEC_W-1] ? -vy_reg : vy_reg;
        xs      = vx_reg >>> iter_reg;
        ys      = vy_reg >>> iter_reg;
        qprev   = 3'(qstep_reg - 4'd1);
        qprod   = Q_W'(prod_reg);
        g2      = (Q_W+1)'(g_reg) <<< 1;
        g2_abs  = g2[Q_W] ? -g2 : g2;
        den     = (Q_W+1)'(n_reg) - ((Q_W+1)'(yz_reg) <<< 1);
        acc_u   = acc_reg;
        rounded = prod_reg + PROD_W'(2048);
        scaled  = rounded[PROD_W-1:12];

        case (qstep_reg[2:0])
            3'd0:    begin qa = qx_reg; qb = qx_reg; end
            3'd1:    begin qa = qy_reg; qb = qy_reg; end
            3'd2:    begin qa = qz_reg; qb = qz_reg; end
            3'd3:    begin qa = qw_reg; qb = qw_reg; end
            3'd4:    begin qa = qx_reg; qb = qy_reg; end
            3'd5:    begin qa = qw_reg; qb = qz_reg; end
            3'd6:    begin qa = qx_reg; qb = qz_reg; end
            3'd7:    begin qa = qw_reg; qb = qy_reg; end
            default: begin qa = qx_reg; qb = qx_reg; end
        endcase

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LINEAR_GAIN:  lin_gain_next = cfg_data;
                CFG_ANGULAR_GAIN: ang_gain_next = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.command)
                        CMD_POSE:
                        begin
                            rob_x_next      = in_data.pos_x;
                            rob_y_next      = in_data.pos_y;
                            qx_next         = in_data.quat_x;
                            qy_next         = in_data.quat_y;
                            qz_next         = in_data.quat_z;
                            qw_next         = in_data.quat_w;
                            pose_known_next = 1'b1;
                        end
                        CMD_TARGET:
                        begin
                            tgt_x_next        = in_data.goal_x;
                            tgt_y_next        = in_data.goal_y;
                            target_known_next = 1'b1;
                        end
                        CMD_TICK:
                        begin
                            res_lin_next = '0;
                            res_ang_next = '0;
                            if (!pose_known_reg)
                            begin
                                res_status_next = STATUS_NO_POSE;
                                state_next      = ST_DONE;
                            end
                            else if (!target_known_reg)
                            begin
                                res_status_next = STATUS_NO_TARGET;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                vx_next = VEC_W'(33'(tgt_x_reg) - 33'(rob_x_reg));
                                vy_next = VEC_W'(33'(tgt_y_reg) - 33'(rob_y_reg));
                                yaw_mode_next = 1'b0;
                                state_next    = ST_VSTART;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_VSTART:
            begin
                shift_next = '0;
                if (vx_reg == '0 && vy_reg == '0)
                begin
                    // A zero vector has angle zero and magnitude zero.
                    z_next = '0;
                    if (yaw_mode_reg)
                    begin
                        state_next = ST_RAD0;
                    end
                    else
                    begin
                        bearing_next = '0;
                        dist_next    = '0;
                        n_next       = '0;
                        yz_next      = '0;
                        num_next     = '0;
                        g_next       = '0;
                        qstep_next   = '0;
                        state_next   = ST_QMUL;
                    end
                end
                else
                begin
                    state_next = ST_NORM;
                end
            end

            ST_NORM:
            begin
                // Scale up until the larger component lies in [2^38, 2^39).
                if (ax[VEC_W-1:38] != '0 || ay[VEC_W-1:38] != '0)
                begin
                    state_next = ST_PRE;
                end
                else if (ax[VEC_W-1:30] == '0 && ay[VEC_W-1:30] == '0)
                begin
                    vx_next    = vx_reg <<< 8;
                    vy_next    = vy_reg <<< 8;
                    shift_next = shift_reg + SHIFT_W'(8);
                end
                else
                begin
                    vx_next    = vx_reg <<< 1;
                    vy_next    = vy_reg <<< 1;
                    shift_next = shift_reg + SHIFT_W'(1);
                end
            end

            ST_PRE:
            begin
                if (vx_reg[VEC_W-1])
                begin
                    z_next  = vy_reg[VEC_W-1] ? -(Z_W'(1) <<< 31) : (Z_W'(1) <<< 31);
                    vx_next = -vx_reg;
                    vy_next = -vy_reg;
                end
                else
                begin
                    z_next = '0;
                end
                iter_next  = '0;
                state_next = ST_ITER;
            end

            ST_ITER:
            begin
                if (!vy_reg[VEC_W-1])
                begin
                    vx_next = vx_reg + ys;
                    vy_next = vy_reg - xs;
                    z_next  = z_reg + $signed({3'b000, atan_ba(iter_reg)});
                end
                else
                begin
                    vx_next = vx_reg - ys;
                    vy_next = vy_reg + xs;
                    z_next  = z_reg - $signed({3'b000, atan_ba(iter_reg)});
                end
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'(CORDIC_STEPS - 1))
                begin
                    if (yaw_mode_reg)
                    begin
                        state_next = ST_RAD0;
                    end
                    else
                    begin
                        bearing_next = z_next;
                        state_next   = ST_MAG0;
                    end
                end
            end

            ST_MAG0:
            begin
                mul_a      = vx_reg[VEC_W-1:8];
                mul_b      = $signed({1'b0, KINV_LO});
                state_next = ST_MAG1;
            end

            ST_MAG1:
            begin
                mul_a      = vx_reg[VEC_W-1:8];
                mul_b      = $signed({1'b0, KINV_HI});
                acc_next   = ACC_W'(prod_reg) + (ACC_W'(1) <<< (shift_reg + 6'd21));
                state_next = ST_MAG2;
            end

            ST_MAG2:
            begin
                acc_next   = acc_reg + (ACC_W'(prod_reg) <<< 16);
                state_next = ST_MAG3;
            end

            ST_MAG3:
            begin
                dist_next  = DIST_W'(acc_u >> (shift_reg + 6'd22));
                n_next     = '0;
                yz_next    = '0;
                num_next   = '0;
                g_next     = '0;
                qstep_next = '0;
                state_next = ST_QMUL;
            end

            ST_QMUL:
            begin
                // Issue one product per cycle, accumulate it in the cycle after, once it is registered.
                if (qstep_reg != 4'd8)
                begin
                    mul_a = MUL_A_W'(qa);
                    mul_b = MUL_B_W'(qb);
                end
                if (qstep_reg != 4'd0)
                begin
                    case (qprev)
                        3'd0:    n_next = n_reg + qprod;
                        3'd1:    begin n_next = n_reg + qprod; yz_next = yz_reg + qprod; end
                        3'd2:    begin n_next = n_reg + qprod; yz_next = yz_reg + qprod; end
                        3'd3:    n_next = n_reg + qprod;
                        3'd4:    num_next = num_reg + qprod;
                        3'd5:    num_next = num_reg + qprod;
                        3'd6:    g_next = g_reg + qprod;
                        3'd7:    g_next = g_reg - qprod;
                        default: ;
                    endcase
                end
                qstep_next = qstep_reg + 4'd1;
                if (qstep_reg == 4'd8)
                begin
                    state_next = ST_QCHK;
                end
            end

            ST_QCHK:
            begin
                // Zero quaternion or gimbal lock gives a yaw of zero.
                if (n_reg == '0 || g2_abs >= (Q_W+1)'(n_reg))
                begin
                    z_next     = '0;
                    state_next = ST_RAD0;
                end
                else
                begin
                    vx_next       = VEC_W'(den);
                    vy_next       = VEC_W'(num_reg) <<< 1;
                    yaw_mode_next = 1'b1;
                    state_next    = ST_VSTART;
                end
            end

            ST_RAD0:
            begin
                mul_a      = MUL_A_W'(bearing_reg);
                mul_b      = $signed({1'b0, PI_LO});
                state_next = ST_RAD1;
            end

            ST_RAD1:
            begin
                mul_a      = MUL_A_W'(bearing_reg);
                mul_b      = $signed({1'b0, PI_HI});
                acc_next   = ACC_W'(prod_reg) + (ACC_W'(1) <<< 44);
                state_next = ST_RAD2;
            end

            ST_RAD2:
            begin
                mul_a      = MUL_A_W'(z_reg);
                mul_b      = $signed({1'b0, PI_LO});
                acc_next   = acc_reg + (ACC_W'(prod_reg) <<< 16);
                state_next = ST_RAD3;
            end

            ST_RAD3:
            begin
                mul_a      = MUL_A_W'(z_reg);
                mul_b      = $signed({1'b0, PI_HI});
                brad_next  = RAD_W'(acc_reg >>> 45);
                acc_next   = ACC_W'(prod_reg) + (ACC_W'(1) <<< 44);
                state_next = ST_RAD4;
            end

            ST_RAD4:
            begin
                acc_next   = acc_reg + (ACC_W'(prod_reg) <<< 16);
                state_next = ST_RAD5;
            end

            ST_RAD5:
            begin
                err_next   = ERR_W'(brad_reg) - ERR_W'(RAD_W'(acc_reg >>> 45));
                mul_a      = $signed({1'b0, dist_reg});
                mul_b      = $signed({1'b0, lin_gain_reg});
                state_next = ST_GAIN0;
            end

            ST_GAIN0:
            begin
                if (scaled > (PROD_W-12)'(32'sh7FFF_FFFF))
                begin
                    res_lin_next = 31'h7FFF_FFFF;
                end
                else
                begin
                    res_lin_next = 31'(scaled);
                end
                mul_a      = MUL_A_W'(err_reg);
                mul_b      = $signed({1'b0, ang_gain_reg});
                state_next = ST_GAIN1;
            end

            ST_GAIN1:
            begin
                if (scaled > (PROD_W-12)'(32'sh7FFF_FFFF))
                begin
                    res_ang_next = 32'sh7FFF_FFFF;
                end
                else if (scaled < (PROD_W-12)'(32'sh8000_0000))
                begin
                    res_ang_next = 32'sh8000_0000;
                end
                else
                begin
                    res_ang_next = 32'(scaled);
                end
                res_status_next = STATUS_OK;
                state_next      = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.linear_speed = res_lin_reg;
                    out_next.angular_rate = res_ang_reg;
                    out_next.status       = res_status_reg;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pose_known_reg   <= 1'b0;
            target_known_reg <= 1'b0;
            lin_gain_reg     <= LINEAR_GAIN_RESET;
            ang_gain_reg     <= ANGULAR_GAIN_RESET;
            out_valid_reg    <= 1'b0;
            yaw_mode_reg     <= 1'b0;
            iter_reg         <= '0;
            qstep_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            pose_known_reg   <= pose_known_next;
            target_known_reg <= target_known_next;
            lin_gain_reg     <= lin_gain_next;
            ang_gain_reg     <= ang_gain_next;
            out_valid_reg    <= out_valid_next;
            yaw_mode_reg     <= yaw_mode_next;
            iter_reg         <= iter_next;
            qstep_reg        <= qstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rob_x_reg      <= rob_x_next;
        rob_y_reg      <= rob_y_next;
        qx_reg         <= qx_next;
        qy_reg         <= qy_next;
        qz_reg         <= qz_next;
        qw_reg         <= qw_next;
        tgt_x_reg      <= tgt_x_next;
        tgt_y_reg      <= tgt_y_next;
        vx_reg         <= vx_next;
        vy_reg         <= vy_next;
        z_reg          <= z_next;
        shift_reg      <= shift_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        n_reg          <= n_next;
        yz_reg         <= yz_next;
        num_reg        <= num_next;
        g_reg          <= g_next;
        dist_reg       <= dist_next;
        bearing_reg    <= bearing_next;
        brad_reg       <= brad_next;
        err_reg        <= err_next;
        res_lin_reg    <= res_lin_next;
        res_ang_reg    <= res_ang_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

endmodule
